[hdl/cvh_pkg.sv]
// Shared codes and control types for the convex hull block.
// No dependencies; imported by cvh_geom and convex_hull_with_containment.
`default_nettype none
package cvh_pkg;
    // input item kinds
    localparam logic [1:0] KIND_LOAD  = 2'd0;
    localparam logic [1:0] KIND_BUILD = 2'd1;
    localparam logic [1:0] KIND_QUERY = 2'd2;

    // result item kinds
    localparam logic [1:0] RK_VERTEX  = 2'd0;
    localparam logic [1:0] RK_CONTAIN = 2'd1;
    localparam logic [1:0] RK_REFUSE  = 2'd2;

    // geometry unit operations
    typedef enum logic {
        GOP_CROSS = 1'b0,
        GOP_DOT   = 1'b1
    } t_gop;

    typedef struct packed {
        logic start;
        t_gop op;
    } t_geom_req;
endpackage
`default_nettype wire

[hdl/cvh_geom.sv]
// Three-stage cross/dot product unit: (a-o)x(b-o) or (a-o).(b-o), exact.
// Depends on cvh_pkg.
`default_nettype none
module cvh_geom
    import cvh_pkg::*;
#(
    parameter int CB = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire t_geom_req                i_req,
    input  wire logic signed [CB-1:0]     i_ax,
    input  wire logic signed [CB-1:0]     i_ay,
    input  wire logic signed [CB-1:0]     i_bx,
    input  wire logic signed [CB-1:0]     i_by,
    input  wire logic signed [CB-1:0]     i_ox,
    input  wire logic signed [CB-1:0]     i_oy,
    output logic                          o_done,
    output logic signed [2*CB+2:0]        o_val
);
    localparam int DW = CB + 1;
    localparam int MW = 2 * DW;
    localparam int GW = MW + 1;

    logic signed [DW-1:0] r_dax, r_day, r_dbx, r_dby;
    logic signed [MW-1:0] r_m1, r_m2;
    logic signed [GW-1:0] r_val;
    t_gop                 r_op1, r_op2;
    logic [2:0]           r_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[1:0], i_req.start};
        end
        // stage 1: offsets from the origin point
        if (i_req.start) begin
            r_dax <= $signed({i_ax[CB-1], i_ax}) - $signed({i_ox[CB-1], i_ox});
            r_day <= $signed({i_ay[CB-1], i_ay}) - $signed({i_oy[CB-1], i_oy});
            r_dbx <= $signed({i_bx[CB-1], i_bx}) - $signed({i_ox[CB-1], i_ox});
            r_dby <= $signed({i_by[CB-1], i_by}) - $signed({i_oy[CB-1], i_oy});
            r_op1 <= i_req.op;
        end
        // stage 2: two products
        r_op2 <= r_op1;
        if (r_op1 == GOP_CROSS) begin
            r_m1 <= r_dax * r_dby;
            r_m2 <= r_dbx * r_day;
        end else begin
            r_m1 <= r_dax * r_dbx;
            r_m2 <= r_day * r_dby;
        end
        // stage 3: combine
        if (r_op2 == GOP_CROSS) begin
            r_val <= $signed({r_m1[MW-1], r_m1}) - $signed({r_m2[MW-1], r_m2});
        end else begin
            r_val <= $signed({r_m1[MW-1], r_m1}) + $signed({r_m2[MW-1], r_m2});
        end
    end

    assign o_done = r_v[2];
    assign o_val  = r_val;
endmodule
`default_nettype wire

[hdl/convex_hull_with_containment.sv]
// Convex hull builder with point containment queries (Graham scan).
// Depends on cvh_pkg and cvh_geom.
//
// Usage:
//  - Input channel i_valid/o_ready carries i_kind, i_px, i_py. Output channel
//    o_valid/i_ready carries one result item per handshake.
//  - Load (kind 0): gives no result. Loads past MAX_POINTS are dropped
//    and o_dropped is set on later results until a successful build.
//  - Build (kind 1): pivot search, selection sort by polar angle (one cross
//    product per compare, plus two dot products for a distance tiebreak
//    when angles are equal, (n-1)*(n-2)/2 compares), Graham scan, then one
//    vertex item per hull vertex. The shared product unit and the point
//    memory, with its single read port, set the build time.
//    Fewer than 3 points gives one refusal item with o_last set.
//  - Query (kind 2): walks the hull edges, one cross product per edge.
//  - One item is handled at a time; o_ready is high only while idle.
//  - The output register holds a result until taken; a stalled receiver
//    simply holds the sequencer before its next result.
//  - Reset clears counts, box, overflow flag and the output valid. The point
//    and hull memories are not cleared; only written entries are ever used.
`default_nettype none
module convex_hull_with_containment
    import cvh_pkg::*;
#(
    parameter int MAX_POINTS = 64,
    parameter int COORD_BITS = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [1:0]                    i_kind,
    input  wire logic signed [COORD_BITS-1:0]  i_px,
    input  wire logic signed [COORD_BITS-1:0]  i_py,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic [1:0]                         o_result_kind,
    output logic signed [COORD_BITS-1:0]       o_vert_x,
    output logic signed [COORD_BITS-1:0]       o_vert_y,
    output logic                               o_inside_res,
    output logic                               o_last,
    output logic signed [COORD_BITS-1:0]       o_box_xmin,
    output logic signed [COORD_BITS-1:0]       o_box_xmax,
    output logic signed [COORD_BITS-1:0]       o_box_ymin,
    output logic signed [COORD_BITS-1:0]       o_box_ymax,
    output logic                               o_dropped
);
    localparam int CB = COORD_BITS;
    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int GW = 2 * CB + 3;

    typedef enum logic [33:0] {
        S_IDLE     = 34'd1 << 0,
        S_REF_OUT  = 34'd1 << 1,
        S_PIV_RD   = 34'd1 << 2,
        S_PIV_EV   = 34'd1 << 3,
        S_PIV_SW0  = 34'd1 << 4,
        S_PIV_SW1  = 34'd1 << 5,
        S_SRT_I    = 34'd1 << 6,
        S_SRT_IV   = 34'd1 << 7,
        S_SRT_JR   = 34'd1 << 8,
        S_SRT_JV   = 34'd1 << 9,
        S_SRT_C    = 34'd1 << 10,
        S_SRT_D1   = 34'd1 << 11,
        S_SRT_D2   = 34'd1 << 12,
        S_SRT_W0   = 34'd1 << 13,
        S_SRT_W1   = 34'd1 << 14,
        S_SCN_INIT = 34'd1 << 15,
        S_SCN_IV   = 34'd1 << 16,
        S_SCN_W1   = 34'd1 << 17,
        S_SCN_RD   = 34'd1 << 18,
        S_SCN_QV   = 34'd1 << 19,
        S_SCN_TST  = 34'd1 << 20,
        S_SCN_C    = 34'd1 << 21,
        S_SCN_HP   = 34'd1 << 22,
        S_SCN_PUSH = 34'd1 << 23,
        S_EM_RD    = 34'd1 << 24,
        S_EM_V     = 34'd1 << 25,
        S_Q_R0     = 34'd1 << 26,
        S_Q_V0     = 34'd1 << 27,
        S_Q_RN     = 34'd1 << 28,
        S_Q_VN     = 34'd1 << 29,
        S_Q_C      = 34'd1 << 30,
        S_Q_2C     = 34'd1 << 31,
        S_Q_2D     = 34'd1 << 32,
        S_Q_OUT    = 34'd1 << 33
    } t_state;

    t_state r_state;

    // control state
    logic [CW-1:0] r_cnt, r_hcnt, r_i, r_j;
    logic [AW-1:0] r_k, r_top;
    logic          r_ovf;
    logic signed [CB-1:0] r_bxmin, r_bxmax, r_bymin, r_bymax;

    // working points: pivot, current best, saved, query, hull top / below top
    logic signed [CB-1:0] r_p0x, r_p0y, r_pkx, r_pky, r_pix, r_piy;
    logic signed [CB-1:0] r_qx, r_qy, r_htx, r_hty, r_hpx, r_hpy;
    logic                 r_ins;
    logic signed [GW-1:0] r_cval;

    // product unit operands
    logic                 r_gstart, n_gstart;
    t_gop                 r_gop;
    logic signed [CB-1:0] r_gax, r_gay, r_gbx, r_gby, r_gox, r_goy;
    t_geom_req            g_req;
    logic                 g_done;
    logic signed [GW-1:0] g_val;
    logic                 g_pos, g_neg, g_zero;

    // memories
    logic [2*CB-1:0] r_pmem [MAX_POINTS];
    logic [2*CB-1:0] r_hmem [MAX_POINTS];
    logic [2*CB-1:0] r_prd, r_hrd;
    logic            s_we, h_we;
    logic [AW-1:0]   s_wa, s_ra, h_wa, h_ra;
    logic [2*CB-1:0] s_wd, h_wd;

    logic signed [CB-1:0] prd_x, prd_y, hrd_x, hrd_y, nxt_x, nxt_y;
    logic                 out_free, q_last, in_acc, ld_out;

    assign prd_x = $signed(r_prd[2*CB-1:CB]);
    assign prd_y = $signed(r_prd[CB-1:0]);
    assign hrd_x = $signed(r_hrd[2*CB-1:CB]);
    assign hrd_y = $signed(r_hrd[CB-1:0]);

    assign out_free = !o_valid || i_ready;
    assign o_ready  = (r_state == S_IDLE);
    assign in_acc   = i_valid && o_ready;
    assign q_last   = (r_i + CW'(1) == r_hcnt);
    // a result state loads the output register this cycle
    assign ld_out   = out_free && (r_state == S_REF_OUT || r_state == S_EM_V ||
                                   r_state == S_Q_OUT);
    // next hull vertex wraps to vertex 0 on the closing edge
    assign nxt_x    = q_last ? r_pix : hrd_x;
    assign nxt_y    = q_last ? r_piy : hrd_y;

    // product requests: compare, tie distances, scan turn, query edge
    assign n_gstart = (r_state == S_SRT_JV) ||
                      (r_state == S_SRT_C && g_done && g_zero) ||
                      (r_state == S_SRT_D1 && g_done) ||
                      (r_state == S_SCN_TST && r_top != '0) ||
                      (r_state == S_Q_VN) ||
                      (r_state == S_Q_2C && g_done && g_zero);

    assign g_req.start = r_gstart;
    assign g_req.op    = r_gop;
    assign g_pos  = !g_val[GW-1] && (g_val != '0);
    assign g_neg  = g_val[GW-1];
    assign g_zero = (g_val == '0);

    cvh_geom #(
        .CB (CB)
    ) u_geom (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (g_req),
        .i_ax    (r_gax),
        .i_ay    (r_gay),
        .i_bx    (r_gbx),
        .i_by    (r_gby),
        .i_ox    (r_gox),
        .i_oy    (r_goy),
        .o_done  (g_done),
        .o_val   (g_val)
    );

    // memory port control
    always_comb begin
        s_ra = r_i[AW-1:0];
        h_ra = r_i[AW-1:0];
        s_we = 1'b0;
        s_wa = r_k;
        s_wd = {r_pix, r_piy};
        h_we = 1'b0;
        h_wa = r_top;
        h_wd = {r_qx, r_qy};
        case (r_state)
            S_IDLE: begin
                s_we = in_acc && (i_kind == KIND_LOAD) && (r_cnt < CW'(MAX_POINTS));
                s_wa = r_cnt[AW-1:0];
                s_wd = {i_px, i_py};
            end
            S_PIV_SW0: begin
                s_we = 1'b1;
                s_wa = '0;
                s_wd = {r_pkx, r_pky};
            end
            S_PIV_SW1, S_SRT_W0: begin
                s_we = 1'b1;
            end
            S_SRT_JR:  s_ra = r_j[AW-1:0];
            S_SRT_W1: begin
                s_we = 1'b1;
                s_wa = r_i[AW-1:0];
                s_wd = {r_pkx, r_pky};
            end
            S_SCN_INIT: s_ra = AW'(1);
            S_SCN_IV: begin
                h_we = 1'b1;
                h_wa = '0;
                h_wd = {r_p0x, r_p0y};
            end
            S_SCN_W1: begin
                h_we = 1'b1;
                h_wa = AW'(1);
                h_wd = {r_htx, r_hty};
            end
            S_SCN_C:    h_ra = r_top - AW'(2);
            S_SCN_PUSH: begin
                h_we = 1'b1;
                h_wa = r_top + AW'(1);
            end
            S_Q_R0:     h_ra = '0;
            S_Q_RN:     h_ra = r_i[AW-1:0] + AW'(1);
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (s_we) begin
            r_pmem[s_wa] <= s_wd;
        end
        r_prd <= r_pmem[s_ra];
    end

    always_ff @(posedge i_clk) begin
        if (h_we) begin
            r_hmem[h_wa] <= h_wd;
        end
        r_hrd <= r_hmem[h_ra];
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_hcnt   <= '0;
            r_ovf    <= 1'b0;
            r_bxmin  <= '0;
            r_bxmax  <= '0;
            r_bymin  <= '0;
            r_bymax  <= '0;
            o_valid  <= 1'b0;
            r_gstart <= 1'b0;
        end else begin
            r_gstart <= n_gstart;
            if (o_valid && i_ready && !ld_out) begin
                o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    r_qx <= i_px;
                    r_qy <= i_py;
                    r_i  <= '0;
                    if (in_acc) begin
                        case (i_kind)
                            KIND_LOAD: begin
                                if (r_cnt < CW'(MAX_POINTS)) begin
                                    r_cnt <= r_cnt + CW'(1);
                                end else begin
                                    r_ovf <= 1'b1;
                                end
                            end
                            KIND_BUILD: begin
                                r_state <= (r_cnt < CW'(3)) ? S_REF_OUT : S_PIV_RD;
                            end
                            KIND_QUERY: begin
                                if (r_hcnt == '0) begin
                                    r_ins   <= 1'b1;
                                    r_state <= S_Q_OUT;
                                end else begin
                                    r_state <= S_Q_R0;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_REF_OUT: begin
                    if (out_free) begin
                        o_valid       <= 1'b1;
                        o_result_kind <= RK_REFUSE;
                        o_vert_x      <= '0;
                        o_vert_y      <= '0;
                        o_inside_res  <= 1'b0;
                        o_last        <= 1'b1;
                        o_box_xmin    <= r_bxmin;
                        o_box_xmax    <= r_bxmax;
                        o_box_ymin    <= r_bymin;
                        o_box_ymax    <= r_bymax;
                        o_dropped     <= r_ovf;
                        r_state       <= S_IDLE;
                    end
                end
                // ---- pivot search and bounding box ----
                S_PIV_RD: r_state <= S_PIV_EV;
                S_PIV_EV: begin
                    if (r_i == '0) begin
                        r_bxmin <= prd_x;
                        r_bxmax <= prd_x;
                        r_bymax <= prd_y;
                        r_pkx   <= prd_x;
                        r_pky   <= prd_y;
                        r_pix   <= prd_x;
                        r_piy   <= prd_y;
                        r_k     <= '0;
                    end else begin
                        if (prd_y < r_pky || (prd_y == r_pky && prd_x < r_pkx)) begin
                            r_pkx <= prd_x;
                            r_pky <= prd_y;
                            r_k   <= r_i[AW-1:0];
                        end
                        if (prd_x > r_bxmax) r_bxmax <= prd_x;
                        if (prd_y > r_bymax) r_bymax <= prd_y;
                        if (prd_x < r_bxmin) r_bxmin <= prd_x;
                    end
                    r_i     <= r_i + CW'(1);
                    r_state <= (r_i + CW'(1) == r_cnt) ? S_PIV_SW0 : S_PIV_RD;
                end
                S_PIV_SW0: begin
                    r_p0x   <= r_pkx;
                    r_p0y   <= r_pky;
                    r_bymin <= r_pky;
                    r_state <= S_PIV_SW1;
                end
                S_PIV_SW1: begin
                    r_i     <= CW'(1);
                    r_state <= S_SRT_I;
                end
                // ---- selection sort by polar angle ----
                S_SRT_I: begin
                    r_state <= (r_i + CW'(1) >= r_cnt) ? S_SCN_INIT : S_SRT_IV;
                end
                S_SRT_IV: begin
                    r_pkx   <= prd_x;
                    r_pky   <= prd_y;
                    r_pix   <= prd_x;
                    r_piy   <= prd_y;
                    r_k     <= r_i[AW-1:0];
                    r_j     <= r_i + CW'(1);
                    r_state <= S_SRT_JR;
                end
                S_SRT_JR: begin
                    r_state <= (r_j >= r_cnt) ? S_SRT_W0 : S_SRT_JV;
                end
                S_SRT_JV: begin
                    r_qx     <= prd_x;
                    r_qy     <= prd_y;
                    r_gax    <= prd_x;
                    r_gay    <= prd_y;
                    r_gbx    <= r_pkx;
                    r_gby    <= r_pky;
                    r_gox    <= r_p0x;
                    r_goy    <= r_p0y;
                    r_gop    <= GOP_CROSS;
                    r_state  <= S_SRT_C;
                end
                S_SRT_C: begin
                    if (g_done) begin
                        if (g_pos) begin
                            r_pkx   <= r_qx;
                            r_pky   <= r_qy;
                            r_k     <= r_j[AW-1:0];
                            r_j     <= r_j + CW'(1);
                            r_state <= S_SRT_JR;
                        end else if (g_zero) begin
                            // equal angle: nearer point first
                            r_gbx    <= r_qx;
                            r_gby    <= r_qy;
                            r_gop    <= GOP_DOT;
                            r_state  <= S_SRT_D1;
                        end else begin
                            r_j     <= r_j + CW'(1);
                            r_state <= S_SRT_JR;
                        end
                    end
                end
                S_SRT_D1: begin
                    if (g_done) begin
                        r_cval   <= g_val;
                        r_gax    <= r_pkx;
                        r_gay    <= r_pky;
                        r_gbx    <= r_pkx;
                        r_gby    <= r_pky;
                        r_state  <= S_SRT_D2;
                    end
                end
                S_SRT_D2: begin
                    if (g_done) begin
                        if (r_cval < g_val) begin
                            r_pkx <= r_qx;
                            r_pky <= r_qy;
                            r_k   <= r_j[AW-1:0];
                        end
                        r_j     <= r_j + CW'(1);
                        r_state <= S_SRT_JR;
                    end
                end
                S_SRT_W0: r_state <= S_SRT_W1;
                S_SRT_W1: begin
                    r_i     <= r_i + CW'(1);
                    r_state <= S_SRT_I;
                end
                // ---- Graham scan ----
                S_SCN_INIT: r_state <= S_SCN_IV;
                S_SCN_IV: begin
                    r_htx   <= prd_x;
                    r_hty   <= prd_y;
                    r_hpx   <= r_p0x;
                    r_hpy   <= r_p0y;
                    r_top   <= AW'(1);
                    r_state <= S_SCN_W1;
                end
                S_SCN_W1: begin
                    r_i     <= CW'(2);
                    r_state <= S_SCN_RD;
                end
                S_SCN_RD: begin
                    if (r_i >= r_cnt) begin
                        r_hcnt  <= CW'(r_top) + CW'(1);
                        r_i     <= '0;
                        r_state <= S_EM_RD;
                    end else begin
                        r_state <= S_SCN_QV;
                    end
                end
                S_SCN_QV: begin
                    r_qx    <= prd_x;
                    r_qy    <= prd_y;
                    r_state <= S_SCN_TST;
                end
                S_SCN_TST: begin
                    if (r_top != '0) begin
                        r_gax    <= r_qx;
                        r_gay    <= r_qy;
                        r_gbx    <= r_htx;
                        r_gby    <= r_hty;
                        r_gox    <= r_hpx;
                        r_goy    <= r_hpy;
                        r_gop    <= GOP_CROSS;
                        r_state  <= S_SCN_C;
                    end else begin
                        r_state <= S_SCN_PUSH;
                    end
                end
                S_SCN_C: begin
                    if (g_done) begin
                        if (!g_neg) begin
                            // pop: the vertex below becomes the top
                            r_top <= r_top - AW'(1);
                            r_htx <= r_hpx;
                            r_hty <= r_hpy;
                            r_state <= (r_top >= AW'(2)) ? S_SCN_HP : S_SCN_TST;
                        end else begin
                            r_state <= S_SCN_PUSH;
                        end
                    end
                end
                S_SCN_HP: begin
                    r_hpx   <= hrd_x;
                    r_hpy   <= hrd_y;
                    r_state <= S_SCN_TST;
                end
                S_SCN_PUSH: begin
                    r_top   <= r_top + AW'(1);
                    r_hpx   <= r_htx;
                    r_hpy   <= r_hty;
                    r_htx   <= r_qx;
                    r_hty   <= r_qy;
                    r_i     <= r_i + CW'(1);
                    r_state <= S_SCN_RD;
                end
                // ---- vertex emission ----
                S_EM_RD: r_state <= S_EM_V;
                S_EM_V: begin
                    if (out_free) begin
                        o_valid       <= 1'b1;
                        o_result_kind <= RK_VERTEX;
                        o_vert_x      <= hrd_x;
                        o_vert_y      <= hrd_y;
                        o_inside_res  <= 1'b0;
                        o_last        <= q_last;
                        o_box_xmin    <= r_bxmin;
                        o_box_xmax    <= r_bxmax;
                        o_box_ymin    <= r_bymin;
                        o_box_ymax    <= r_bymax;
                        o_dropped     <= r_ovf;
                        r_i           <= r_i + CW'(1);
                        if (q_last) begin
                            r_cnt   <= '0;
                            r_ovf   <= 1'b0;
                            r_state <= S_IDLE;
                        end else begin
                            r_state <= S_EM_RD;
                        end
                    end
                end
                // ---- containment query ----
                S_Q_R0: r_state <= S_Q_V0;
                S_Q_V0: begin
                    // r_pi holds vertex 0, r_hp the current edge start
                    r_pix   <= hrd_x;
                    r_piy   <= hrd_y;
                    r_hpx   <= hrd_x;
                    r_hpy   <= hrd_y;
                    r_state <= S_Q_RN;
                end
                S_Q_RN: r_state <= S_Q_VN;
                S_Q_VN: begin
                    r_htx    <= nxt_x;
                    r_hty    <= nxt_y;
                    r_gbx    <= r_qx;
                    r_gby    <= r_qy;
                    r_gop    <= GOP_CROSS;
                    if (r_hcnt == CW'(2)) begin
                        r_gax   <= r_pix;
                        r_gay   <= r_piy;
                        r_gox   <= nxt_x;
                        r_goy   <= nxt_y;
                        r_state <= S_Q_2C;
                    end else begin
                        r_gax   <= nxt_x;
                        r_gay   <= nxt_y;
                        r_gox   <= r_hpx;
                        r_goy   <= r_hpy;
                        r_state <= S_Q_C;
                    end
                end
                S_Q_C: begin
                    if (g_done) begin
                        if (g_neg) begin
                            r_ins   <= 1'b0;
                            r_state <= S_Q_OUT;
                        end else if (q_last) begin
                            r_ins   <= 1'b1;
                            r_state <= S_Q_OUT;
                        end else begin
                            r_i     <= r_i + CW'(1);
                            r_hpx   <= r_htx;
                            r_hpy   <= r_hty;
                            r_state <= S_Q_RN;
                        end
                    end
                end
                S_Q_2C: begin
                    if (g_done) begin
                        if (!g_zero) begin
                            r_ins   <= 1'b0;
                            r_state <= S_Q_OUT;
                        end else begin
                            // collinear: check it lies between the two ends
                            r_gax    <= r_pix;
                            r_gay    <= r_piy;
                            r_gbx    <= r_htx;
                            r_gby    <= r_hty;
                            r_gox    <= r_qx;
                            r_goy    <= r_qy;
                            r_gop    <= GOP_DOT;
                            r_state  <= S_Q_2D;
                        end
                    end
                end
                S_Q_2D: begin
                    if (g_done) begin
                        r_ins   <= !g_pos;
                        r_state <= S_Q_OUT;
                    end
                end
                S_Q_OUT: begin
                    if (out_free) begin
                        o_valid       <= 1'b1;
                        o_result_kind <= RK_CONTAIN;
                        o_vert_x      <= '0;
                        o_vert_y      <= '0;
                        o_inside_res  <= r_ins;
                        o_last        <= 1'b0;
                        o_box_xmin    <= r_bxmin;
                        o_box_xmax    <= r_bxmax;
                        o_box_ymin    <= r_bymin;
                        o_box_ymax    <= r_bymax;
                        o_dropped     <= r_ovf;
                        r_state       <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // point count never passes the store depth
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(MAX_POINTS))
        else $error("point count beyond store depth");

    // product results only arrive while the sequencer waits for one
    a_geom_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        g_done |-> (r_state == S_SRT_C || r_state == S_SRT_D1 || r_state == S_SRT_D2 ||
                    r_state == S_SCN_C || r_state == S_Q_C || r_state == S_Q_2C ||
                    r_state == S_Q_2D))
        else $error("product result with no pending request");

    // a refusal is always the final item of its build
    a_refuse_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result_kind == RK_REFUSE) |-> o_last)
        else $error("refusal without last");

    // a new result is loaded only into a free output register
    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_vert_x) && $stable(o_last)))
        else $error("output overwritten while stalled");
endmodule
`default_nettype wire
